// File: src/hid_descriptor_button_parser_macros.svh
// ----------------------------------------------------------------------------
// HID descriptor button parser assertion macros
// Shared concurrent assertion shorthands for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef HID_DESCRIPTOR_BUTTON_PARSER_MACROS_SVH
`define HID_DESCRIPTOR_BUTTON_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is active.
`define HDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is active.
`define HDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/hdp_pkg.sv
// ----------------------------------------------------------------------------
// HID descriptor button parser package
// Payload types, parser phase codes and item field codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hdp_pkg;

  // One descriptor byte request.
  typedef struct packed {
    logic [7:0] desc_byte;
    logic       end_of_descriptor;
  } hdp_in_t;

  // One parse result.
  typedef struct packed {
    logic       parse_status;
    logic [7:0] button_count;
  } hdp_out_t;

  // Parser phases.
  localparam logic [2:0] PH_HEADER     = 3'd0;
  localparam logic [2:0] PH_LONG_SIZE  = 3'd1;
  localparam logic [2:0] PH_LONG_TAG   = 3'd2;
  localparam logic [2:0] PH_LONG_DATA  = 3'd3;
  localparam logic [2:0] PH_SHORT_DATA = 3'd4;

  // Item header codes.
  localparam logic [3:0] LONG_TAG        = 4'hF;
  localparam logic [7:0] BUTTON_PAGE     = 8'h09;
  localparam logic [1:0] TYPE_GLOBAL     = 2'd1;
  localparam logic [1:0] TYPE_LOCAL      = 2'd2;
  localparam logic [3:0] GTAG_USAGE_PAGE = 4'd0;
  localparam logic [3:0] LTAG_USAGE_MIN  = 4'd1;
  localparam logic [3:0] LTAG_USAGE_MAX  = 4'd2;
  localparam logic [1:0] SIZE_CODE_FOUR  = 2'd3;
  localparam logic [2:0] SIZE_FOUR       = 3'd4;

endpackage

`default_nettype wire

// File: src/hdp_parser.sv
// ----------------------------------------------------------------------------
// HID descriptor button parser core
// Holds the item parser state and advances it by one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_descriptor_button_parser_macros.svh"

module hdp_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire hdp_pkg::hdp_in_t byte_i,
  output hdp_pkg::hdp_out_t   res_o
);
  import hdp_pkg::*;

  logic [2:0] phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [1:0] type_q, type_d;
  logic [3:0] tag_q, tag_d;
  logic [2:0] size_q, size_d;
  logic [7:0] fdb_q, fdb_d;
  logic       page_q, page_d;
  logic [7:0] min_q, min_d;
  logic [7:0] max_q, max_d;
  logic       err_q, err_d;

  logic       a_apply;
  logic [1:0] a_type;
  logic [3:0] a_tag;
  logic [2:0] a_size;
  logic [7:0] a_fdb;
  logic [7:0] a_low;
  logic [7:0] b;

  assign b = byte_i.desc_byte;

  // Next-state logic for one descriptor byte.
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    type_d  = type_q;
    tag_d   = tag_q;
    size_d  = size_q;
    fdb_d   = fdb_q;
    page_d  = page_q;
    min_d   = min_q;
    max_d   = max_q;
    err_d   = err_q;
    a_apply = 1'b0;
    a_type  = type_q;
    a_tag   = tag_q;
    a_size  = size_q;
    a_fdb   = fdb_q;
    a_low   = 8'd0;
    res_o   = '0;

    if (step_i && !err_q) begin
      case (phase_q)
        PH_LONG_SIZE: begin
          left_d  = b;
          phase_d = PH_LONG_TAG;
        end
        PH_LONG_TAG: begin
          if (left_q == 8'd0) begin
            err_d   = 1'b1;
            phase_d = PH_HEADER;
          end else begin
            phase_d = PH_LONG_DATA;
          end
        end
        PH_LONG_DATA: begin
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            err_d   = 1'b1;
            phase_d = PH_HEADER;
          end
        end
        PH_SHORT_DATA: begin
          if (left_q == {5'd0, size_q}) begin
            a_fdb = b;
          end
          fdb_d  = a_fdb;
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            a_apply = 1'b1;
            phase_d = PH_HEADER;
          end
        end
        default: begin
          // Item header: unused phase codes land here too.
          a_type = b[3:2];
          a_tag  = b[7:4];
          type_d = a_type;
          tag_d  = a_tag;
          if (a_tag == LONG_TAG) begin
            phase_d = PH_LONG_SIZE;
          end else begin
            a_size = (b[1:0] == SIZE_CODE_FOUR) ? SIZE_FOUR : {1'b0, b[1:0]};
            size_d = a_size;
            left_d = {5'd0, a_size};
            if (a_size == 3'd0) begin
              a_apply = 1'b1;
              phase_d = PH_HEADER;
            end else begin
              phase_d = PH_SHORT_DATA;
            end
          end
        end
      endcase
    end

    // Apply a completed short item.
    a_low = (a_size != 3'd0) ? a_fdb : 8'd0;
    if (a_apply) begin
      if (a_type == TYPE_GLOBAL && a_tag == GTAG_USAGE_PAGE) begin
        if (a_low == BUTTON_PAGE) begin
          page_d = 1'b1;
        end
      end else if (a_type == TYPE_LOCAL && a_size != 3'd0 && page_q) begin
        if (a_tag == LTAG_USAGE_MIN) begin
          min_d = a_low;
        end else if (a_tag == LTAG_USAGE_MAX) begin
          max_d = a_low;
        end
      end
    end

    // Result from the updated state.
    res_o.parse_status = err_d;
    res_o.button_count = err_d ? 8'd0 : (max_d - min_d + 8'd1);

    // The final byte returns everything to its reset values.
    if (step_i && byte_i.end_of_descriptor) begin
      phase_d = PH_HEADER;
      left_d  = 8'd0;
      type_d  = 2'd0;
      tag_d   = 4'd0;
      size_d  = 3'd0;
      fdb_d   = 8'd0;
      page_d  = 1'b0;
      min_d   = 8'd0;
      max_d   = 8'd0;
      err_d   = 1'b0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      left_q  <= 8'd0;
      type_q  <= 2'd0;
      tag_q   <= 4'd0;
      size_q  <= 3'd0;
      fdb_q   <= 8'd0;
      page_q  <= 1'b0;
      min_q   <= 8'd0;
      max_q   <= 8'd0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      type_q  <= type_d;
      tag_q   <= tag_d;
      size_q  <= size_d;
      fdb_q   <= fdb_d;
      page_q  <= page_d;
      min_q   <= min_d;
      max_q   <= max_d;
      err_q   <= err_d;
    end
  end

  // The final byte leaves a clean parser behind.
  `HDP_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, step_i && byte_i.end_of_descriptor,
    phase_q == PH_HEADER && !err_q && !page_q)
  // Once a long item has failed the parser sits at the header phase.
  `HDP_ASSERT_IMPL(a_err_parks, clk_i, rst_ni, err_q, phase_q == PH_HEADER)
  // Long data is only entered with bytes still owed.
  `HDP_ASSERT_IMPL(a_long_data_left, clk_i, rst_ni, phase_q == PH_LONG_DATA,
    left_q != 8'd0)

endmodule

`default_nettype wire

// File: src/hid_descriptor_button_parser.sv
// ----------------------------------------------------------------------------
// HID descriptor button parser
// Walks HID report descriptor bytes and reports the button usage range.
// ----------------------------------------------------------------------------
// Usage:
//   Descriptor bytes enter on the in channel (valid/ready), one request per
//   byte, with end_of_descriptor set on the final byte. Only that final byte
//   produces a request on the out channel: parse_status and button_count.
//   A final byte is accepted into the input register; its result is
//   loaded into the result register when that byte leaves the input
//   register, and is presented from there.
//   Throughput: one byte per cycle unless stalled; the parser state
//   update is a single pass of shallow logic from input register to state.
//   When the receiver stalls, bytes that are not final keep flowing; a final
//   byte waits in the input register until the result register is free,
//   and the in channel then holds ready low.
//   Reset clears the parser to the item header phase and empties both
//   registers. After each final byte the parser returns to its reset state
//   for the next descriptor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_descriptor_button_parser_macros.svh"

module hid_descriptor_button_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hdp_pkg::hdp_in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hdp_pkg::hdp_out_t  out_data_o
);
  import hdp_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  hdp_in_t  s1_data_q;
  logic     s1_adv;
  logic     out_valid_q, out_valid_d;
  hdp_out_t out_data_q;
  hdp_out_t res;

  // A final byte may only advance when the result register can take it.
  assign s1_adv     = s1_valid_q &
                      (~s1_data_q.end_of_descriptor | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  hdp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .byte_i (s1_data_q),
    .res_o  (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_data_q.end_of_descriptor) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_data_q.end_of_descriptor) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An error result never carries a button count.
  `HDP_ASSERT_IMPL(a_err_count, clk_i, rst_ni, out_valid_q && out_data_q.parse_status,
    out_data_q.button_count == 8'd0)
  // A fresh result comes only from a final byte leaving the input register.
  `HDP_ASSERT_IMPL(a_res_source, clk_i, rst_ni, $rose(out_valid_q),
    $past(s1_adv && s1_data_q.end_of_descriptor))
  // A final byte blocked by a stalled result also blocks the input.
  `HDP_ASSERT_IMPL(a_final_blocks, clk_i, rst_ni,
    s1_valid_q && s1_data_q.end_of_descriptor && out_valid_q && !out_ready_i,
    !in_ready_o)

endmodule

`default_nettype wire
